// File: hdl/mcr_pkg.sv
package mcr_pkg;

    // Coordinate and arithmetic widths
    localparam int COORD_BITS = 12;
    localparam int FRAME_BITS = 13;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int MAG_BITS   = COORD_BITS;
    localparam int SQ_BITS    = 2 * MAG_BITS + 2;
    localparam int ROOT_BITS  = SQ_BITS / 2;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int STEP_BITS  = COORD_BITS + 2;
    localparam int DEC_BITS   = COORD_BITS + 4;
    localparam int PIX_BITS   = COORD_BITS + 3;
    localparam int OCT_BITS   = 3;
    localparam int CNT_BITS   = $clog2(ROOT_BITS);

    localparam logic [FRAME_BITS-1:0] FRAME_CAP   = FRAME_BITS'(1 << COORD_BITS);
    localparam logic [FRAME_BITS-1:0] FRAME_RESET = FRAME_BITS'(400);

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef struct packed {
        logic                          opcode;
        logic signed [COORD_BITS-1:0]  center_x;
        logic signed [COORD_BITS-1:0]  center_y;
        logic signed [COORD_BITS-1:0]  edge_x;
        logic signed [COORD_BITS-1:0]  edge_y;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  pixel_valid;
        logic                  last_of_step;
        logic                  circle_done;
    } out_item_t;

    // Top-level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_EMIT
    } state_t;

    // Root unit sequencer
    typedef enum logic [1:0] {
        RP_IDLE,
        RP_SQUARE,
        RP_ROOT
    } root_phase_t;

    typedef struct packed {
        logic busy;
        logic done;
    } root_status_t;

    typedef struct packed {
        logic                load;
        logic [OCT_BITS-1:0] index;
        logic                last;
        logic                done;
    } emit_ctrl_t;

endpackage

// File: hdl/mcr_root.sv
// Serial distance unit: squares |dx| and |dy| one multiplier bit per cycle,
// then takes the integer root two radicand bits per cycle.
module mcr_root
    import mcr_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic signed [COORD_BITS-1:0] edge_x,
    input  logic signed [COORD_BITS-1:0] edge_y,
    output root_status_t                 status,
    output logic [ROOT_BITS-1:0]         radius
);

    root_phase_t phase_reg, phase_next;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [SQ_BITS-1:0]   acc_reg, acc_next;
    logic [SQ_BITS-1:0]   mcand_x_reg, mcand_y_reg;
    logic [MAG_BITS-1:0]  mplr_x_reg, mplr_y_reg;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;

    logic signed [DIFF_BITS-1:0] diff_x, diff_y;
    logic [MAG_BITS-1:0]         mag_x, mag_y;
    logic [REM_BITS+1:0]         rem_shift, trial;
    logic                        fits;
    logic                        sq_last, root_last;

    // Magnitudes of the center-to-edge offsets
    always_comb begin
        diff_x = DIFF_BITS'(center_x) - DIFF_BITS'(edge_x);
        diff_y = DIFF_BITS'(center_y) - DIFF_BITS'(edge_y);
        mag_x  = diff_x[DIFF_BITS-1] ? MAG_BITS'(-diff_x) : MAG_BITS'(diff_x);
        mag_y  = diff_y[DIFF_BITS-1] ? MAG_BITS'(-diff_y) : MAG_BITS'(diff_y);
    end

    assign sq_last   = (cnt_reg == CNT_BITS'(MAG_BITS - 1));
    assign root_last = (cnt_reg == CNT_BITS'(ROOT_BITS - 1));

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            RP_IDLE:   if (start) phase_next = RP_SQUARE;
            RP_SQUARE: if (sq_last) phase_next = RP_ROOT;
            RP_ROOT:   if (root_last) phase_next = RP_IDLE;
            default:   phase_next = RP_IDLE;
        endcase
    end

    // Status outputs
    always_comb begin
        status.busy = (phase_reg != RP_IDLE);
        status.done = (phase_reg == RP_ROOT) && root_last;
    end

    // One multiplier bit of each square per cycle
    always_comb begin
        acc_next = acc_reg
                 + (mplr_x_reg[0] ? mcand_x_reg : '0)
                 + (mplr_y_reg[0] ? mcand_y_reg : '0);
    end

    // One root bit per cycle, restoring form
    always_comb begin
        rem_shift = {rem_reg, acc_reg[SQ_BITS-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        fits      = (rem_shift >= trial);
        rem_next  = fits ? REM_BITS'(rem_shift - trial) : REM_BITS'(rem_shift);
        root_next = {root_reg[ROOT_BITS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= RP_IDLE;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            if (phase_next != phase_reg) begin
                cnt_reg <= '0;
            end else if (phase_reg != RP_IDLE) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge aclk) begin
        case (phase_reg)
            RP_IDLE: begin
                if (start) begin
                    acc_reg     <= '0;
                    mcand_x_reg <= SQ_BITS'(mag_x);
                    mcand_y_reg <= SQ_BITS'(mag_y);
                    mplr_x_reg  <= mag_x;
                    mplr_y_reg  <= mag_y;
                    rem_reg     <= '0;
                    root_reg    <= '0;
                end
            end
            RP_SQUARE: begin
                acc_reg     <= acc_next;
                mcand_x_reg <= mcand_x_reg << 1;
                mcand_y_reg <= mcand_y_reg << 1;
                mplr_x_reg  <= mplr_x_reg >> 1;
                mplr_y_reg  <= mplr_y_reg >> 1;
            end
            RP_ROOT: begin
                acc_reg  <= acc_reg << 2;
                rem_reg  <= rem_next;
                root_reg <= root_next;
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign radius = root_next;

endmodule

// File: hdl/mcr_pixel.sv
// Forms one symmetric pixel per cycle while the consumer keeps up, clips it to
// the frame and holds it in the output register until the consumer takes it.
module mcr_pixel
    import mcr_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  emit_ctrl_t                   ctrl,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic signed [STEP_BITS-1:0]  off_x,
    input  logic signed [STEP_BITS-1:0]  off_y,
    input  logic [FRAME_BITS-1:0]        frame_width,
    input  logic [FRAME_BITS-1:0]        frame_height,
    output logic                         can_load,
    output logic                         m_valid,
    input  logic                         m_ready,
    output out_item_t                    m_item
);

    logic                       valid_reg;
    out_item_t                  item_reg, item_next;
    logic                       swap, neg_x, neg_y;
    logic signed [PIX_BITS-1:0] a, b, px, py;
    logic [FRAME_BITS-1:0]      w_lim, h_lim;
    logic                       in_frame;

    // Octant order: (+x,+y) (+y,+x) (-y,+x) (-x,+y) (-x,-y) (-y,-x) (+y,-x) (+x,-y)
    always_comb begin
        swap  = (ctrl.index inside {3'd1, 3'd2, 3'd5, 3'd6});
        neg_x = (ctrl.index inside {[3'd2:3'd5]});
        neg_y = (ctrl.index inside {[3'd4:3'd7]});
        a     = swap ? PIX_BITS'(off_y) : PIX_BITS'(off_x);
        b     = swap ? PIX_BITS'(off_x) : PIX_BITS'(off_y);
        px    = PIX_BITS'(center_x) + (neg_x ? -a : a);
        py    = PIX_BITS'(center_y) + (neg_y ? -b : b);
    end

    // Frame clip, registers above the coordinate range count as full range
    always_comb begin
        w_lim    = (frame_width  > FRAME_CAP) ? FRAME_CAP : frame_width;
        h_lim    = (frame_height > FRAME_CAP) ? FRAME_CAP : frame_height;
        in_frame = !px[PIX_BITS-1] && !py[PIX_BITS-1]
                && ($unsigned(px) < PIX_BITS'(w_lim))
                && ($unsigned(py) < PIX_BITS'(h_lim));
        item_next.pixel_x      = in_frame ? px[COORD_BITS-1:0] : '0;
        item_next.pixel_y      = in_frame ? py[COORD_BITS-1:0] : '0;
        item_next.pixel_valid  = in_frame;
        item_next.last_of_step = ctrl.last;
        item_next.circle_done  = ctrl.done;
    end

    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            item_reg <= item_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

// File: hdl/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer. A start item (opcode 0) takes a center and a
// point on the circle; the radius is the integer root of the squared
// distance, worked out by a serial unit: shift-add squaring, then root
// iteration, so a start keeps the input closed until the root is done and
// gives no result. A step item (opcode 1) gives eight pixels, one per cycle
// through the output register while the consumer keeps m_ready high, in the
// order (+x,+y) (+y,+x) (-y,+x) (-x,+y) (-x,-y) (-y,-x) (+y,-x) (+x,-y).
// Pixels outside [0, frame_width) x [0, frame_height), each bound capped at
// 4096, come out with pixel_valid low and zero coordinates. circle_done marks
// the eighth pixel of the final step. A step with no circle in progress is
// taken and dropped. Frame registers are written through the cfg channel,
// which is always ready.
module midpoint_circle_rasterizer
    import mcr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  in_item_t                s_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output out_item_t               m_item,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [FRAME_BITS-1:0]   cfg_data
);

    state_t state_reg, state_next;

    logic [FRAME_BITS-1:0]        frame_width_reg, frame_height_reg;
    logic signed [COORD_BITS-1:0] center_x_reg, center_y_reg;
    logic signed [STEP_BITS-1:0]  step_x_reg, step_y_reg;
    logic signed [STEP_BITS-1:0]  step_x_next, step_y_next;
    logic signed [DEC_BITS-1:0]   decision_reg, decision_next;
    logic signed [STEP_BITS-1:0]  pix_x_reg, pix_y_reg;
    logic                         active_reg;
    logic                         done_reg;
    logic [OCT_BITS-1:0]          oct_reg;

    logic                 s_take, is_start, is_step;
    logic                 root_start;
    root_status_t         root_stat;
    logic [ROOT_BITS-1:0] radius;
    emit_ctrl_t           emit;
    logic                 can_load;
    logic                 last_oct;

    assign s_take    = s_valid && s_ready;
    assign is_start  = (s_item.opcode == OP_START);
    assign is_step   = (s_item.opcode == OP_STEP);
    assign last_oct  = (oct_reg == {OCT_BITS{1'b1}});
    assign cfg_ready = 1'b1;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_take && is_start) begin
                    state_next = ST_ROOT;
                end else if (s_take && is_step && active_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_ROOT: if (root_stat.done) state_next = ST_IDLE;
            ST_EMIT: if (can_load && last_oct) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        root_start = (state_reg == ST_IDLE) && s_take && is_start;
        emit.load  = (state_reg == ST_EMIT) && can_load;
        emit.index = oct_reg;
        emit.last  = last_oct;
        emit.done  = last_oct && done_reg;
    end

    // Midpoint decision update
    always_comb begin
        step_x_next = step_x_reg + 1'b1;
        if (decision_reg[DEC_BITS-1]) begin
            decision_next = decision_reg + (DEC_BITS'(step_x_reg) <<< 1) + DEC_BITS'(3);
            step_y_next   = step_y_reg;
        end else begin
            decision_next = decision_reg
                          + ((DEC_BITS'(step_x_reg) - DEC_BITS'(step_y_reg)) <<< 1)
                          + DEC_BITS'(5);
            step_y_next   = step_y_reg - 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            active_reg       <= 1'b0;
            oct_reg          <= '0;
            frame_width_reg  <= FRAME_RESET;
            frame_height_reg <= FRAME_RESET;
        end else begin
            state_reg <= state_next;
            if (root_stat.done) begin
                active_reg <= 1'b1;
            end else if (root_start) begin
                active_reg <= 1'b0;
            end else if (s_take && is_step && active_reg) begin
                active_reg <= !(step_y_next < step_x_next);
            end
            if (emit.load) begin
                oct_reg <= oct_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:          frame_width_reg  <= frame_width_reg;
                endcase
            end
        end
    end

    // Circle state
    always_ff @(posedge aclk) begin
        if (root_start) begin
            center_x_reg <= s_item.center_x;
            center_y_reg <= s_item.center_y;
        end
        if (root_stat.done) begin
            step_x_reg   <= '0;
            step_y_reg   <= STEP_BITS'(radius);
            decision_reg <= DEC_BITS'(3) - (DEC_BITS'(radius) <<< 1);
        end else if (s_take && is_step && active_reg) begin
            pix_x_reg    <= step_x_reg;
            pix_y_reg    <= step_y_reg;
            done_reg     <= (step_y_next < step_x_next);
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            decision_reg <= decision_next;
        end
    end

    mcr_root u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .center_x (s_item.center_x),
        .center_y (s_item.center_y),
        .edge_x   (s_item.edge_x),
        .edge_y   (s_item.edge_y),
        .status   (root_stat),
        .radius   (radius)
    );

    mcr_pixel u_pixel (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (emit),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .off_x        (pix_x_reg),
        .off_y        (pix_y_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .can_load     (can_load),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item)
    );

    // The root unit runs only while the input side is closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !root_stat.busy)
        else $error("root unit busy while accepting items");

    // The eighth pixel of a step closes the emit burst
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.load && last_oct) |=> (state_reg == ST_IDLE))
        else $error("emit burst did not end after eighth pixel");

    // End of circle only on the last pixel of a step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.circle_done) |-> m_item.last_of_step)
        else $error("circle_done without last_of_step");

endmodule

// File: tb/tb.sv
module tb;
    import mcr_pkg::*;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0] index;
        logic [FRAME_BITS-1:0]   data;
    } frame_write_t;

    // DUT ports, all inputs known from time zero
    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    in_item_t                s_item    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    out_item_t               m_item;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [FRAME_BITS-1:0]   cfg_data  = '0;

    // Pending stimulus and expected pixels
    in_item_t     item_q[$];
    frame_write_t frame_write_q[$];
    out_item_t    pixel_expect_q[$];
    out_item_t    exp_px;

    // Predicted rasterizer state
    logic [FRAME_BITS-1:0] frame_w = FRAME_RESET;
    logic [FRAME_BITS-1:0] frame_h = FRAME_RESET;
    int ctr_x, ctr_y, cur_x, cur_y, dec;
    bit drawing;

    // Flow control knobs and run statistics
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int error_count     = 0;
    int starts_seen     = 0;
    int steps_seen      = 0;
    int pixels_checked  = 0;
    int frame_writes    = 0;

    midpoint_circle_rasterizer DUT (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Floor square root, one result bit at a time from the top
    function automatic int unsigned int_root(longint unsigned n);
        longint unsigned r;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            longint unsigned t;
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    // Clip one symmetric point against the frame (registers capped at 4096)
    function automatic out_item_t make_pixel(int px, int py, bit last, bit done);
        out_item_t p;
        int w, h;
        bit in_frame;
        w = int'((frame_w > FRAME_CAP) ? FRAME_CAP : frame_w);
        h = int'((frame_h > FRAME_CAP) ? FRAME_CAP : frame_h);
        in_frame = px >= 0 && py >= 0 && px < w && py < h;
        p.pixel_x      = in_frame ? COORD_BITS'(px) : '0;
        p.pixel_y      = in_frame ? COORD_BITS'(py) : '0;
        p.pixel_valid  = in_frame;
        p.last_of_step = last;
        p.circle_done  = done;
        return p;
    endfunction

    // Advance the predicted state by one accepted item
    function automatic void predict_item(in_item_t it);
        int x, y;
        longint dx, dy;
        bit done;
        if (it.opcode == OP_START) begin
            ctr_x = $signed(it.center_x);
            ctr_y = $signed(it.center_y);
            dx = ctr_x - $signed(it.edge_x);
            dy = ctr_y - $signed(it.edge_y);
            cur_x = 0;
            cur_y = int_root(dx * dx + dy * dy);
            dec = 3 - 2 * cur_y;
            drawing = 1'b1;
            starts_seen++;
            return;
        end
        // step with no circle in progress is dropped
        if (!drawing) return;
        x = cur_x;
        y = cur_y;
        if (dec < 0) begin
            dec += 2 * x + 3;
        end else begin
            dec += 2 * (x - y) + 5;
            cur_y = y - 1;
        end
        cur_x = x + 1;
        done = cur_y < cur_x;
        if (done) drawing = 1'b0;
        // eight-way symmetry, fixed output order
        pixel_expect_q.push_back(make_pixel(ctr_x + x, ctr_y + y, 1'b0, 1'b0));
        pixel_expect_q.push_back(make_pixel(ctr_x + y, ctr_y + x, 1'b0, 1'b0));
        pixel_expect_q.push_back(make_pixel(ctr_x - y, ctr_y + x, 1'b0, 1'b0));
        pixel_expect_q.push_back(make_pixel(ctr_x - x, ctr_y + y, 1'b0, 1'b0));
        pixel_expect_q.push_back(make_pixel(ctr_x - x, ctr_y - y, 1'b0, 1'b0));
        pixel_expect_q.push_back(make_pixel(ctr_x - y, ctr_y - x, 1'b0, 1'b0));
        pixel_expect_q.push_back(make_pixel(ctr_x + y, ctr_y - x, 1'b0, 1'b0));
        pixel_expect_q.push_back(make_pixel(ctr_x + x, ctr_y - y, 1'b1, done));
        steps_seen++;
    endfunction

    // Input channel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_item(s_item);
            if (!s_valid || s_ready) begin
                if (item_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_item  <= item_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Frame register write driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FRAME_WIDTH) frame_w = cfg_data;
                else frame_h = cfg_data;
                frame_writes++;
            end
            if (!cfg_valid || cfg_ready) begin
                if (frame_write_q.size() > 0) begin
                    {cfg_index, cfg_data} <= frame_write_q.pop_front();
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                pixels_checked++;
                if (pixel_expect_q.size() == 0) begin
                    $display({"%0t: unexpected pixel: expected none, got x=%0d y=%0d",
                              " valid=%0b last=%0b done=%0b"},
                             $time, m_item.pixel_x, m_item.pixel_y, m_item.pixel_valid,
                             m_item.last_of_step, m_item.circle_done);
                    error_count++;
                end else begin
                    exp_px = pixel_expect_q.pop_front();
                    if (m_item.pixel_x !== exp_px.pixel_x
                            || m_item.pixel_y !== exp_px.pixel_y
                            || m_item.pixel_valid !== exp_px.pixel_valid
                            || m_item.last_of_step !== exp_px.last_of_step
                            || m_item.circle_done !== exp_px.circle_done) begin
                        $display({"%0t: pixel mismatch: expected x=%0d y=%0d valid=%0b",
                                  " last=%0b done=%0b, got x=%0d y=%0d valid=%0b",
                                  " last=%0b done=%0b"}, $time,
                                 exp_px.pixel_x, exp_px.pixel_y, exp_px.pixel_valid,
                                 exp_px.last_of_step, exp_px.circle_done,
                                 m_item.pixel_x, m_item.pixel_y, m_item.pixel_valid,
                                 m_item.last_of_step, m_item.circle_done);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void push_item(op_t op, int cx, int cy, int ex, int ey);
        in_item_t it;
        it.opcode   = op;
        it.center_x = COORD_BITS'(cx);
        it.center_y = COORD_BITS'(cy);
        it.edge_x   = COORD_BITS'(ex);
        it.edge_y   = COORD_BITS'(ey);
        item_q.push_back(it);
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    // Wait until every item is taken and every pixel has come out;
    // sampled on the falling edge so the drivers have settled
    task automatic wait_drained(int settle_cycles);
        @(negedge aclk);
        while (item_q.size() != 0 || s_valid || pixel_expect_q.size() != 0)
            @(negedge aclk);
        repeat (settle_cycles) @(posedge aclk);
    endtask

    task automatic set_frame(int w, int h);
        frame_write_q.push_back({CFG_FRAME_WIDTH, FRAME_BITS'(w)});
        frame_write_q.push_back({CFG_FRAME_HEIGHT, FRAME_BITS'(h)});
        while (frame_write_q.size() != 0 || cfg_valid) @(negedge aclk);
    endtask

    // Mostly whole circles of small radius, some cut short by a restart,
    // some huge circles for a few steps, and a little noise
    function automatic void queue_random(int target);
        int made, kind, cx, cy, ex, ey, n, full;
        longint dx, dy;
        made = 0;
        while (made < target) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                push_item(op_t'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
                made++;
            end else begin
                if ($urandom_range(3) == 0) begin
                    cx = int'($urandom_range(4095)) - 2048;
                    cy = int'($urandom_range(4095)) - 2048;
                end else begin
                    cx = int'($urandom_range(1148)) - 48;
                    cy = int'($urandom_range(1148)) - 48;
                end
                if (kind < 88) begin
                    ex = clamp_coord(cx + int'($urandom_range(80)) - 40);
                    ey = clamp_coord(cy + int'($urandom_range(80)) - 40);
                end else begin
                    ex = int'($urandom_range(4095)) - 2048;
                    ey = int'($urandom_range(4095)) - 2048;
                end
                dx = cx - ex;
                dy = cy - ey;
                // about r/sqrt(2) steps finish a circle; a couple extra are ignored
                full = int'(int_root(dx * dx + dy * dy)) * 724 / 1024 + 2;
                if (kind >= 88) n = $urandom_range(10, 1);
                else if ($urandom_range(4) == 0) n = $urandom_range(full);
                else n = full;
                push_item(OP_START, cx, cy, ex, ey);
                repeat (n) push_item(OP_STEP, $urandom, $urandom, $urandom, $urandom);
                made += 1 + n;
            end
        end
    endfunction

    task automatic run_phase(int w, int h, int idle_pct, int stall_pct);
        set_frame(w, h);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        queue_random(20);
        // sender holds off here until the block has emptied
        wait_drained(0);
        queue_random(20);
        wait_drained(40);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items, frame at its reset size
        push_item(OP_STEP, 0, 0, 0, 0);                  // nothing drawing yet
        push_item(OP_START, 0, 0, 0, 0);                 // zero radius at origin
        push_item(OP_STEP, 0, 0, 0, 0);
        push_item(OP_STEP, -1, -1, -1, -1);              // circle already finished
        push_item(OP_START, -2048, -2048, 2047, 2047);   // largest radius
        push_item(OP_STEP, 2047, 2047, -2048, -2048);
        push_item(OP_STEP, 0, 0, 0, 0);
        push_item(OP_START, 2047, 2047, -2048, -2048);   // restart while drawing
        push_item(OP_STEP, -1, 0, -1, 0);
        push_item(OP_START, 200, 200, 203, 204);         // radius 5, whole circle
        repeat (5) push_item(OP_STEP, 0, -1, 0, -1);
        push_item(OP_START, 399, 0, 399, 3);             // straddles frame corner
        repeat (4) push_item(OP_STEP, 0, 0, 0, 0);
        wait_drained(40);

        // Random phases over frame sizes and flow control mixes
        run_phase(4096, 4096, 0, 0);
        run_phase(8191, 4097, 64, 0);
        run_phase(0, 1, 0, 64);
        run_phase(1, 0, 21, 21);
        run_phase(640, 480, 0, 0);
        run_phase($urandom_range(4096, 1), $urandom_range(4096, 1), 21, 21);

        wait_drained(50);
        $display("Summary: %0d circle starts, %0d drawing steps, %0d pixels checked,",
                 starts_seen, steps_seen, pixels_checked);
        $display("         %0d frame writes covering zero, one, capped and oversize frames.",
                 frame_writes);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
